### rtl/ler_pkg.sv
// Package for the line endpoint Euler rotation core.
// Holds coordinate and coefficient types, register indexes and the
// shift-and-saturate helper. No dependencies.
package ler_pkg;

  localparam int COORD_W  = 24;
  localparam int CS_W     = 16;
  localparam int FRAC_W   = 14;
  localparam int PROD_W   = COORD_W + CS_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int SH_W     = SUM_W - FRAC_W;
  localparam int NUM_PTS  = 2;
  localparam int PT_W     = 3 * COORD_W;
  localparam int DATA_W   = NUM_PTS * PT_W;
  localparam int CFG_AW   = 3;

  // register indexes on the configuration port
  localparam logic [CFG_AW-1:0] REG_COS_A = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SIN_A = 3'd1;
  localparam logic [CFG_AW-1:0] REG_COS_B = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SIN_B = 3'd3;
  localparam logic [CFG_AW-1:0] REG_COS_G = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SIN_G = 3'd5;

  localparam logic signed [CS_W-1:0] CS_ONE  = 16'sd16384;
  localparam logic signed [CS_W-1:0] CS_ZERO = 16'sd0;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [CS_W-1:0]    cs_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    cs_t cos_a;
    cs_t sin_a;
    cs_t cos_b;
    cs_t sin_b;
    cs_t cos_g;
    cs_t sin_g;
  } rot_cfg_t;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;

  // floor(v / 2^FRAC_W), clamped to the coordinate range
  function automatic coord_t sat_shift(input sum_t v);
    logic [SH_W-1:0] t;
    t = v[SUM_W-1:FRAC_W];
    if ((&t[SH_W-1:COORD_W-1]) || !(|t[SH_W-1:COORD_W-1])) begin
      sat_shift = t[COORD_W-1:0];
    end else if (t[SH_W-1]) begin
      sat_shift = COORD_MIN;
    end else begin
      sat_shift = COORD_MAX;
    end
  endfunction

endpackage

### rtl/ler_rot_stage.sv
// One plane rotation: p' = p*c + q*s, q' = q*c - p*s, r passes through.
// Two register levels: products, then sum/shift/saturate. Uses ler_pkg.
module ler_rot_stage import ler_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  coord_t p_i,
  input  coord_t q_i,
  input  coord_t r_i,
  input  cs_t    c_i,
  input  cs_t    s_i,
  output coord_t p_o,
  output coord_t q_o,
  output coord_t r_o
);

  prod_t  pc_r, qs_r, qc_r, ps_r;
  prod_t  pc_nxt, qs_nxt, qc_nxt, ps_nxt;
  coord_t r1_r;
  coord_t p_r, q_r, r2_r;
  sum_t   sum_p, sum_q;

  always_comb begin
    pc_nxt = p_i * c_i;
    qs_nxt = q_i * s_i;
    qc_nxt = q_i * c_i;
    ps_nxt = p_i * s_i;
  end

  // exact sums, subtraction avoids negating a full-scale sine
  always_comb begin
    sum_p = SUM_W'(pc_r) + SUM_W'(qs_r);
    sum_q = SUM_W'(qc_r) - SUM_W'(ps_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r <= pc_nxt;
      qs_r <= qs_nxt;
      qc_r <= qc_nxt;
      ps_r <= ps_nxt;
      r1_r <= r_i;
      p_r  <= sat_shift(sum_p);
      q_r  <= sat_shift(sum_q);
      r2_r <= r1_r;
    end
  end

  assign p_o = p_r;
  assign q_o = q_r;
  assign r_o = r2_r;

endmodule

### rtl/ler_lane.sv
// One endpoint lane: rotations about x, y and z in three chained stages.
// Uses ler_pkg and ler_rot_stage.
module ler_lane import ler_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  rot_cfg_t cfg_i,
  input  coord_t   x_i,
  input  coord_t   y_i,
  input  coord_t   z_i,
  output coord_t   x_o,
  output coord_t   y_o,
  output coord_t   z_o
);

  coord_t x1, y1, z1;
  coord_t x2, y2, z2;

  // about x: (y, z) rotate, x rides along
  ler_rot_stage u_rot_x (
    .clk (clk), .en (en),
    .p_i (y_i), .q_i (z_i), .r_i (x_i),
    .c_i (cfg_i.cos_a), .s_i (cfg_i.sin_a),
    .p_o (y1), .q_o (z1), .r_o (x1)
  );

  // about y: (x, z) rotate
  ler_rot_stage u_rot_y (
    .clk (clk), .en (en),
    .p_i (x1), .q_i (z1), .r_i (y1),
    .c_i (cfg_i.cos_b), .s_i (cfg_i.sin_b),
    .p_o (x2), .q_o (z2), .r_o (y2)
  );

  // about z: operands swapped so x' = x*c - y*s, y' = y*c + x*s
  ler_rot_stage u_rot_z (
    .clk (clk), .en (en),
    .p_i (y2), .q_i (x2), .r_i (z2),
    .c_i (cfg_i.cos_g), .s_i (cfg_i.sin_g),
    .p_o (y_o), .q_o (x_o), .r_o (z_o)
  );

endmodule

### rtl/line_endpoint_euler_rotation_core.sv
// Top level of the line endpoint Euler rotation core.
// Two endpoint lanes (ler_lane) and an output register that merges them.
// Uses ler_pkg.
//
// Usage:
//   in_*  : one line segment per transfer, both endpoints in in_tdata.
//   out_* : the rotated segment, same packing, one per input transfer.
//   cfg_* : six Q2.14 sine/cosine registers, written while idle.
// Each endpoint is rotated about x, then y, then z; every step truncates
// toward minus infinity and saturates to the 24-bit coordinate range.
// From input transfer to out_tvalid, data passes three rotation stages
// (multiply, then add/shift/clamp in each) and then the output register.
// Throughput is one segment per cycle while out_tready
// is high. When the receiver stalls, the whole pipeline holds: in_tready
// drops whenever a result waits in the output register with out_tready
// low, and empty slots inside the pipeline do not fill meanwhile.
// Reset empties the pipeline and sets the registers to an identity
// rotation (cosines 1.0, sines 0).
module line_endpoint_euler_rotation_core import ler_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // ax, ay, az, bx, by, bz
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // rax, ray, raz, rbx, rby, rbz
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CS_W-1:0]   cfg_wdata
);

  localparam int LANE_LAT = 6;

  rot_cfg_t                cfg_r;
  logic [LANE_LAT-1:0]     vld_r;
  logic                    out_vld_r;
  logic [DATA_W-1:0]       out_data_r;
  logic                    en;
  coord_t                  res [NUM_PTS][3];

  // pipeline advances unless a result sits unclaimed at the output
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_a <= CS_ONE;
      cfg_r.sin_a <= CS_ZERO;
      cfg_r.cos_b <= CS_ONE;
      cfg_r.sin_b <= CS_ZERO;
      cfg_r.cos_g <= CS_ONE;
      cfg_r.sin_g <= CS_ZERO;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COS_A: cfg_r.cos_a <= cfg_wdata;
        REG_SIN_A: cfg_r.sin_a <= cfg_wdata;
        REG_COS_B: cfg_r.cos_b <= cfg_wdata;
        REG_SIN_B: cfg_r.sin_b <= cfg_wdata;
        REG_COS_G: cfg_r.cos_g <= cfg_wdata;
        REG_SIN_G: cfg_r.sin_g <= cfg_wdata;
        default: ;
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < NUM_PTS; gi++) begin : g_lane
      ler_lane u_lane (
        .clk   (clk),
        .en    (en),
        .cfg_i (cfg_r),
        .x_i   (in_tdata[gi*PT_W             +: COORD_W]),
        .y_i   (in_tdata[gi*PT_W + COORD_W   +: COORD_W]),
        .z_i   (in_tdata[gi*PT_W + 2*COORD_W +: COORD_W]),
        .x_o   (res[gi][0]),
        .y_o   (res[gi][1]),
        .z_o   (res[gi][2])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[LANE_LAT-2:0], in_tvalid};
      out_vld_r <= vld_r[LANE_LAT-1];
    end
  end

  // merge: both lanes land in one output word
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {res[1][2], res[1][1], res[1][0],
                     res[0][2], res[0][1], res[0][0]};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/ler_checker.sv
// Port-level checks for line_endpoint_euler_rotation_core, bound to it below.
// Uses ler_pkg for widths.
module ler_checker import ler_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata
);

  // a result waiting at the output must hold until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // the input side may only stall behind a waiting result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  // nothing emerges in the cycle right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind line_endpoint_euler_rotation_core ler_checker u_ler_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
